/* design/tstx_pkg.sv */
// Shared types and constants for the timestamped TX sample packer.
// No dependencies; tstx_front, tstx_back and the top level import this package.
package tstx_pkg;

  // Buffer size limits and register defaults
  localparam int unsigned MaxBufferSamplesDefault = 65536;
  localparam int unsigned SizeW                   = 17;
  localparam logic [SizeW-1:0] DefaultBufferSamples = 17'd4096;

  // Queue depths
  localparam int unsigned MidDepthDefault = 2;
  localparam int unsigned OutDepthDefault = 4;

  // CS12 high-nibble mask
  localparam logic [7:0] NibbleHigh = 8'hf0;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 17;
  localparam logic [CfgIdxW-1:0] CfgIdxFormat = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxTsEn   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxSize   = 2'd2;

  // Result kinds
  localparam logic KindPad    = 1'b0;
  localparam logic KindSample = 1'b1;

  // Sample encodings; code 3 decodes as CS16
  typedef enum logic [1:0] {
    FmtCs16 = 2'd0,
    FmtCs12 = 2'd1,
    FmtCs8  = 2'd2
  } fmt_e;

  // Result sequencer phase
  typedef enum logic [1:0] {
    PhPre,
    PhSample,
    PhTail
  } phase_e;

  typedef struct packed {
    logic [1:0]       sample_format;
    logic             timestamp_enable;
    logic [SizeW-1:0] buffer_samples;
  } cfg_t;

  typedef struct packed {
    logic [31:0] sample_raw;
    logic        has_time;
    logic [63:0] timestamp;
    logic        end_burst;
  } in_word_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample_i;
    logic signed [15:0] sample_q;
    logic [SizeW-1:0]   pad_count;
    logic [63:0]        buffer_tag;
    logic               closes_buffer;
    logic               last;
  } out_word_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic signed [15:0] sample_i;
    logic signed [15:0] sample_q;
    logic               end_burst;
    logic               gap_small;  // gap fits in SizeW bits
    logic [SizeW-1:0]   gap_lo;     // low bits of the gap, zero if untimed
    logic [63:0]        tick;       // running tick at the sample
  } mid_word_t;

endpackage

/* design/tstx_fifo.sv */
// Small first-word-fall-through queue of flat words.
// Standalone; used for the front/back queue and the result queue.
module tstx_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* design/tstx_front.sv */
// Front end: sample format conversion, running tick tracking and gap compute.
// Depends on tstx_pkg.
module tstx_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tstx_pkg::cfg_t      cfg_i,
  input  logic                accept_i,
  input  tstx_pkg::in_word_t  in_word_i,
  output tstx_pkg::mid_word_t mid_word_o
);
  import tstx_pkg::*;

  logic [63:0] tick_q, tick_d;
  logic [63:0] diff;
  logic [63:0] base_tick;
  logic        timed;
  logic [7:0]  b0, b1, b2;
  logic [15:0] si, sq;

  assign timed = in_word_i.has_time && cfg_i.timestamp_enable;
  assign b0    = in_word_i.sample_raw[7:0];
  assign b1    = in_word_i.sample_raw[15:8];
  assign b2    = in_word_i.sample_raw[23:16];

  // Format conversion to MSB-aligned 16-bit I/Q
  always_comb begin
    case (cfg_i.sample_format)
      FmtCs12: begin
        si = {b1[3:0], b0, 4'b0000};
        sq = {b2, b1 & NibbleHigh};
      end
      FmtCs8: begin
        si = {b0, 8'h00};
        sq = {b1, 8'h00};
      end
      default: begin
        si = in_word_i.sample_raw[15:0];
        sq = in_word_i.sample_raw[31:16];
      end
    endcase
  end

  // Tick at the sample: a timed item jumps the tick to its timestamp
  assign diff      = in_word_i.timestamp - tick_q;
  assign base_tick = timed ? in_word_i.timestamp : tick_q;
  assign tick_d    = base_tick + 64'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else if (accept_i) begin
      tick_q <= tick_d;
    end
  end

  // Classified word; an untimed item has a zero gap
  always_comb begin
    mid_word_o.sample_i  = $signed(si);
    mid_word_o.sample_q  = $signed(sq);
    mid_word_o.end_burst = in_word_i.end_burst;
    mid_word_o.gap_small = !timed || (diff[63:SizeW] == '0);
    mid_word_o.gap_lo    = timed ? diff[SizeW-1:0] : '0;
    mid_word_o.tick      = base_tick;
  end

endmodule

/* design/tstx_back.sv */
// Back end: buffer fill state and result sequencer, one result word per cycle
// while an item waits and the result queue has room. Depends on tstx_pkg.
module tstx_back #(
  parameter int unsigned MaxBufferSamples = tstx_pkg::MaxBufferSamplesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tstx_pkg::cfg_t      cfg_i,
  input  logic                mid_empty_i,
  input  tstx_pkg::mid_word_t mid_word_i,
  output logic                mid_pop_o,
  input  logic                out_full_i,
  output logic                out_push_o,
  output tstx_pkg::out_word_t out_word_o
);
  import tstx_pkg::*;

  phase_e           phase_q, phase_d;
  logic             open_q, open_d;
  logic [SizeW-1:0] fill_q, fill_d;
  logic [63:0]      tag_q, tag_d;
  logic             commit;
  logic             go;

  logic [SizeW-1:0] size, room, pfill, fill1, fill2, fill3;
  logic             pfull, pre_present, open1, sclose, tail_present;
  logic [63:0]      tag2;
  out_word_t        pre_res, smp_res, tail_res;

  assign go = !mid_empty_i && !out_full_i;

  // Effective buffer size
  always_comb begin
    if (cfg_i.buffer_samples == '0) begin
      size = SizeW'(1);
    end else if (32'(cfg_i.buffer_samples) > MaxBufferSamples) begin
      size = SizeW'(MaxBufferSamples);
    end else begin
      size = cfg_i.buffer_samples;
    end
  end

  // Gap padding, limited to the room left
  assign room        = (fill_q >= size) ? '0 : size - fill_q;
  assign pfull       = !(mid_word_i.gap_small && (mid_word_i.gap_lo < room));
  assign pfill       = pfull ? room : mid_word_i.gap_lo;
  assign pre_present = open_q && ((pfill != '0) || pfull);

  // Buffer after padding; a closed buffer reopens at the sample tick
  assign open1 = open_q && !pfull;
  assign fill1 = fill_q + mid_word_i.gap_lo;
  assign fill2 = open1 ? fill1 : '0;
  assign tag2  = open1 ? tag_q : mid_word_i.tick;

  // Sample placement and end of burst
  assign fill3        = fill2 + 1'b1;
  assign sclose       = (fill3 >= size);
  assign tail_present = !sclose && mid_word_i.end_burst;

  // Candidate results
  always_comb begin
    pre_res.kind          = KindPad;
    pre_res.sample_i      = '0;
    pre_res.sample_q      = '0;
    pre_res.pad_count     = pfill;
    pre_res.buffer_tag    = tag_q;
    pre_res.closes_buffer = pfull;
    pre_res.last          = 1'b0;

    smp_res.kind          = KindSample;
    smp_res.sample_i      = mid_word_i.sample_i;
    smp_res.sample_q      = mid_word_i.sample_q;
    smp_res.pad_count     = '0;
    smp_res.buffer_tag    = tag2;
    smp_res.closes_buffer = sclose;
    smp_res.last          = !tail_present;

    tail_res.kind          = KindPad;
    tail_res.sample_i      = '0;
    tail_res.sample_q      = '0;
    tail_res.pad_count     = size - fill3;
    tail_res.buffer_tag    = tag2;
    tail_res.closes_buffer = 1'b1;
    tail_res.last          = 1'b1;
  end

  // Sequencer next state
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PhPre: begin
        if (go) begin
          if (pre_present) begin
            phase_d = PhSample;
          end else if (tail_present) begin
            phase_d = PhTail;
          end
        end
      end
      PhSample: begin
        if (go) begin
          phase_d = tail_present ? PhTail : PhPre;
        end
      end
      PhTail: begin
        if (go) begin
          phase_d = PhPre;
        end
      end
      default: phase_d = PhPre;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    out_word_o = smp_res;
    commit     = 1'b0;
    unique case (phase_q)
      PhPre: begin
        if (pre_present) begin
          out_word_o = pre_res;
        end else begin
          commit = !tail_present;
        end
      end
      PhSample: begin
        commit = !tail_present;
      end
      PhTail: begin
        out_word_o = tail_res;
        commit     = 1'b1;
      end
      default: commit = 1'b0;
    endcase
  end

  assign out_push_o = go;
  assign mid_pop_o  = go && commit;

  // Buffer state after the item
  assign open_d = !(sclose || mid_word_i.end_burst);
  assign fill_d = fill3;
  assign tag_d  = tag2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhPre;
      open_q  <= 1'b0;
      fill_q  <= '0;
      tag_q   <= '0;
    end else begin
      phase_q <= phase_d;
      if (mid_pop_o) begin
        open_q <= open_d;
        fill_q <= fill_d;
        tag_q  <= tag_d;
      end
    end
  end

endmodule

/* design/timestamped_tx_sample_packer_top.sv */
// Top level of the timestamped TX sample packer: config registers and queues.
// Depends on tstx_pkg, tstx_fifo, tstx_front and tstx_back.
//
//   channel   handshake          payload            direction
//   input     push / full        in_word_i          in
//   result    empty / pop        out_word_o         out
//   config    cfg_we_i           cfg_idx_i, data    in
//
// An item is accepted every cycle while full is low. The result sequencer
// drains one result word per cycle while the result queue has room and an
// item is waiting. An item makes one result, two with a gap, close or tail
// pad, three with a pad both before and after the sample.
// An item is registered in the front/back queue and its results in the result queue.
// Reset clears the running tick, buffer state and both queues, and sets the config registers to their defaults.
// The front/back queue lets inputs continue while the result side stalls.
module timestamped_tx_sample_packer_top #(
  parameter int unsigned MaxBufferSamples = tstx_pkg::MaxBufferSamplesDefault,
  parameter int unsigned MidDepth         = tstx_pkg::MidDepthDefault,
  parameter int unsigned OutDepth         = tstx_pkg::OutDepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tstx_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tstx_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  tstx_pkg::in_word_t              in_word_i,
  output logic                            empty,
  input  logic                            pop,
  output tstx_pkg::out_word_t             out_word_o
);
  import tstx_pkg::*;

  cfg_t      cfg_q;
  mid_word_t front_word, mid_head;
  out_word_t back_word;
  logic      accept;
  logic      mid_empty, mid_pop;
  logic      out_full, out_push;
  logic [$bits(mid_word_t)-1:0] mid_rdata;
  logic [$bits(out_word_t)-1:0] out_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_format    <= FmtCs16;
      cfg_q.timestamp_enable <= 1'b0;
      cfg_q.buffer_samples   <= DefaultBufferSamples;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxFormat: cfg_q.sample_format    <= cfg_data_i[1:0];
        CfgIdxTsEn:   cfg_q.timestamp_enable <= cfg_data_i[0];
        CfgIdxSize:   cfg_q.buffer_samples   <= cfg_data_i[SizeW-1:0];
        default:      cfg_q                  <= cfg_q;
      endcase
    end
  end

  assign accept = push && !full;

  tstx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .accept_i   (accept),
    .in_word_i  (in_word_i),
    .mid_word_o (front_word)
  );

  // Front to back queue
  tstx_fifo #(
    .Width ($bits(mid_word_t)),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_word),
    .full_o  (full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  assign mid_head = mid_word_t'(mid_rdata);

  tstx_back #(
    .MaxBufferSamples (MaxBufferSamples)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_empty_i (mid_empty),
    .mid_word_i  (mid_head),
    .mid_pop_o   (mid_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_word_o  (back_word)
  );

  // Result queue
  tstx_fifo #(
    .Width ($bits(out_word_t)),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (back_word),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .empty_o (empty)
  );

  assign out_word_o = out_word_t'(out_rdata);

endmodule
